FILE: src/pps_pkg.sv
// Shared widths, command and status types, and a helper of the priority scheduler.
package pps_pkg;

	localparam int unsigned DEF_MAX_PROCS = 16;

	localparam int unsigned ARR_W      = 16;
	localparam int unsigned BURST_W    = 16;
	localparam int unsigned PRIO_W     = 8;
	localparam int unsigned IDX_OUT_W  = 6;
	localparam int unsigned OUT_TIME_W = 22;
	// The internal clock is one bit wider than the reported times, so it never wraps.
	localparam int unsigned TIME_W     = OUT_TIME_W + 1;

	localparam logic [OUT_TIME_W-1:0] TIME_LIMIT = '1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan_start;
		logic scan_step;
		logic out_phase;
		logic eval;
		logic commit;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;
		logic found;
		logic run_done;
		logic out_last;
	} sts_t;

	// Clamp an internal time to the largest reportable value.
	function automatic logic [OUT_TIME_W-1:0] sat_time(input logic [TIME_W-1:0] t);
		return t[TIME_W-1] ? TIME_LIMIT : t[OUT_TIME_W-1:0];
	endfunction

endpackage

FILE: src/pps_ctrl.sv
// Controller state machine of the priority scheduler: sequences load, run steps and reporting.
module pps_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          last_process,
	input  pps_pkg::sts_t sts,
	output pps_pkg::cmd_t cmd,
	output logic          busy
);
	import pps_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SCAN   = 6'b000010,
		S_EVAL   = 6'b000100,
		S_COMMIT = 6'b001000,
		S_OSCAN  = 6'b010000,
		S_EMIT   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (last_process) begin
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (sts.found) begin
					state_d = S_COMMIT;
				end else begin
					// Nothing has arrived: the clock jumps ahead and the table is searched again.
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_COMMIT: begin
				cmd.commit     = 1'b1;
				cmd.scan_start = 1'b1;
				state_d        = sts.run_done ? S_OSCAN : S_SCAN;
			end
			S_OSCAN: begin
				cmd.scan_step = 1'b1;
				cmd.out_phase = 1'b1;
				if (sts.scan_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				cmd.emit      = 1'b1;
				cmd.out_phase = 1'b1;
				if (sts.out_last) begin
					state_d = S_IDLE;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_OSCAN;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

FILE: src/pps_dpath.sv
// Datapath of the priority scheduler: record memories, scan pipeline, clock and result registers.
module pps_dpath #(
	parameter int unsigned MAX_PROCS = pps_pkg::DEF_MAX_PROCS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pps_pkg::cmd_t                    cmd,
	output pps_pkg::sts_t                    sts,
	input  logic [pps_pkg::ARR_W-1:0]        arrival_time,
	input  logic [pps_pkg::BURST_W-1:0]      burst_length,
	input  logic [pps_pkg::PRIO_W-1:0]       prio_level,
	output logic                             strobe,
	output logic [pps_pkg::IDX_OUT_W-1:0]    proc_index,
	output logic [pps_pkg::OUT_TIME_W-1:0]   completion_time,
	output logic [pps_pkg::OUT_TIME_W-1:0]   turnaround_time,
	output logic [pps_pkg::OUT_TIME_W-1:0]   waiting_time,
	output logic                             table_overflowed,
	output logic                             last_result
);
	import pps_pkg::*;

	localparam int unsigned IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);

	// Record memories, one entry per loaded process.
	logic [ARR_W-1:0]   arr_mem   [MAX_PROCS];
	logic [BURST_W-1:0] burst_mem [MAX_PROCS];
	logic [BURST_W-1:0] rem_mem   [MAX_PROCS];
	logic [PRIO_W-1:0]  prio_mem  [MAX_PROCS];
	logic [TIME_W-1:0]  fin_mem   [MAX_PROCS];

	logic [ARR_W-1:0]   arr_rd_q;
	logic [BURST_W-1:0] burst_rd_q;
	logic [BURST_W-1:0] rem_rd_q;
	logic [PRIO_W-1:0]  prio_rd_q;
	logic [TIME_W-1:0]  fin_rd_q;

	// Control state.
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     completed_q;
	logic [CNT_W-1:0]     emitted_q;
	logic                 ovf_q;
	logic [MAX_PROCS-1:0] done_q;
	logic [TIME_W-1:0]    clk_q;
	logic                 iss_q;
	logic                 rd_vld_q;
	logic [IDX_W-1:0]     addr_q;
	logic [IDX_W-1:0]     rd_idx_q;
	logic                 found_q;
	logic                 later_q;
	logic                 strobe_q;

	// Running choice of the scan.
	logic [IDX_W-1:0]   best_idx_q;
	logic [PRIO_W-1:0]  best_prio_q;
	logic [ARR_W-1:0]   best_arr_q;
	logic [BURST_W-1:0] best_rem_q;
	logic [BURST_W-1:0] best_burst_q;
	logic [TIME_W-1:0]  best_fin_q;
	logic [ARR_W-1:0]   next_arr_q;
	logic [BURST_W-1:0] span_q;

	logic [IDX_OUT_W-1:0]  idx_out_q;
	logic [OUT_TIME_W-1:0] fin_out_q;
	logic [OUT_TIME_W-1:0] tat_out_q;
	logic [OUT_TIME_W-1:0] wait_out_q;
	logic                  ovf_out_q;
	logic                  last_out_q;

	logic               has_room;
	logic               do_write;
	logic [IDX_W-1:0]   wr_idx;
	logic [BURST_W-1:0] burst_fix;
	logic               addr_last;
	logic               rd_done;
	logic               arrived;
	logic               better_run;
	logic               take_run;
	logic               take_next;
	logic               take_out;
	logic               take_best;
	logic [TIME_W-1:0]  gap;
	logic               use_gap;
	logic [BURST_W-1:0] span_d;
	logic [TIME_W-1:0]  clk_sum;
	logic [BURST_W-1:0] rem_next;
	logic               fin_now;
	logic               out_last;
	logic [TIME_W-1:0]  tat;
	logic [TIME_W-1:0]  wait_t;

	assign has_room  = cnt_q < CNT_W'(MAX_PROCS);
	assign do_write  = cmd.load && has_room;
	assign wr_idx    = cnt_q[IDX_W-1:0];
	assign burst_fix = (burst_length == '0) ? BURST_W'(1) : burst_length;
	assign addr_last = (CNT_W'(addr_q) + 1'b1) == cnt_q;

	// Scan compare: a running candidate is ranked by priority, then arrival, then index.
	assign rd_done    = done_q[rd_idx_q];
	assign arrived    = TIME_W'(arr_rd_q) <= clk_q;
	assign better_run = !found_q || (prio_rd_q > best_prio_q) ||
	                    ((prio_rd_q == best_prio_q) && (arr_rd_q < best_arr_q));
	assign take_run   = rd_vld_q && !cmd.out_phase && !rd_done && arrived && better_run;
	assign take_next  = rd_vld_q && !cmd.out_phase && !rd_done && !arrived &&
	                    (!later_q || (arr_rd_q < next_arr_q));
	assign take_out   = rd_vld_q && cmd.out_phase && rd_done &&
	                    (!found_q || (arr_rd_q < best_arr_q));
	assign take_best  = take_run || take_out;

	// The chosen process runs until it finishes or the next arrival, whichever is first.
	assign gap     = TIME_W'(next_arr_q) - clk_q;
	assign use_gap = later_q && (gap < TIME_W'(best_rem_q));
	assign span_d  = use_gap ? gap[BURST_W-1:0] : best_rem_q;

	assign clk_sum  = clk_q + TIME_W'(span_q);
	assign rem_next = best_rem_q - span_q;
	assign fin_now  = (rem_next == '0);
	assign out_last = (emitted_q + 1'b1) == cnt_q;

	assign tat    = best_fin_q - TIME_W'(best_arr_q);
	assign wait_t = tat - TIME_W'(best_burst_q);

	always_ff @(posedge clk) begin
		if (do_write) begin
			arr_mem[wr_idx]   <= arrival_time;
			burst_mem[wr_idx] <= burst_fix;
			prio_mem[wr_idx]  <= prio_level;
		end
		if (do_write) begin
			rem_mem[wr_idx] <= burst_fix;
		end else if (cmd.commit) begin
			rem_mem[best_idx_q] <= rem_next;
		end
		if (cmd.commit) begin
			fin_mem[best_idx_q] <= clk_sum;
		end
		if (cmd.scan_step && iss_q) begin
			arr_rd_q   <= arr_mem[addr_q];
			burst_rd_q <= burst_mem[addr_q];
			rem_rd_q   <= rem_mem[addr_q];
			prio_rd_q  <= prio_mem[addr_q];
			fin_rd_q   <= fin_mem[addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (take_best) begin
			best_idx_q   <= rd_idx_q;
			best_prio_q  <= prio_rd_q;
			best_arr_q   <= arr_rd_q;
			best_rem_q   <= rem_rd_q;
			best_burst_q <= burst_rd_q;
			best_fin_q   <= fin_rd_q;
		end
		if (take_next) begin
			next_arr_q <= arr_rd_q;
		end
		if (cmd.eval) begin
			span_q <= span_d;
		end
		if (cmd.scan_step && iss_q) begin
			rd_idx_q <= addr_q;
		end
		if (cmd.emit) begin
			idx_out_q  <= IDX_OUT_W'(best_idx_q);
			fin_out_q  <= sat_time(best_fin_q);
			tat_out_q  <= sat_time(tat);
			wait_out_q <= sat_time(wait_t);
			ovf_out_q  <= ovf_q;
			last_out_q <= out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			completed_q <= '0;
			emitted_q   <= '0;
			ovf_q       <= 1'b0;
			done_q      <= '0;
			clk_q       <= '0;
			iss_q       <= 1'b0;
			rd_vld_q    <= 1'b0;
			addr_q      <= '0;
			found_q     <= 1'b0;
			later_q     <= 1'b0;
			strobe_q    <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
			if (cmd.load) begin
				if (has_room) begin
					cnt_q <= cnt_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.scan_start) begin
				iss_q    <= 1'b1;
				addr_q   <= '0;
				rd_vld_q <= 1'b0;
				found_q  <= 1'b0;
				later_q  <= 1'b0;
			end else begin
				if (cmd.scan_step) begin
					rd_vld_q <= iss_q;
					if (iss_q) begin
						if (addr_last) begin
							iss_q <= 1'b0;
						end else begin
							addr_q <= addr_q + 1'b1;
						end
					end
				end
				if (take_best) begin
					found_q <= 1'b1;
				end
				if (take_next) begin
					later_q <= 1'b1;
				end
			end
			if (cmd.eval && !found_q) begin
				clk_q <= TIME_W'(next_arr_q);
			end
			if (cmd.commit) begin
				clk_q <= clk_sum;
				if (fin_now) begin
					done_q[best_idx_q] <= 1'b1;
					completed_q        <= completed_q + 1'b1;
				end
			end
			if (cmd.emit) begin
				done_q[best_idx_q] <= 1'b0;
				if (out_last) begin
					cnt_q       <= '0;
					ovf_q       <= 1'b0;
					completed_q <= '0;
					emitted_q   <= '0;
					clk_q       <= '0;
				end else begin
					emitted_q <= emitted_q + 1'b1;
				end
			end
		end
	end

	always_comb begin
		sts           = '0;
		sts.scan_done = !iss_q && !rd_vld_q;
		sts.found     = found_q;
		sts.run_done  = fin_now && ((completed_q + 1'b1) == cnt_q);
		sts.out_last  = out_last;
	end

	assign strobe           = strobe_q;
	assign proc_index       = idx_out_q;
	assign completion_time  = fin_out_q;
	assign turnaround_time  = tat_out_q;
	assign waiting_time     = wait_out_q;
	assign table_overflowed = ovf_out_q;
	assign last_result      = last_out_q;

endmodule

FILE: src/preemptive_priority_scheduler_unit.sv
// Top level of the preemptive priority scheduler: controller plus datapath.
//
// Usage: process records are offered on start with arrival_time, burst_length,
// prio_level and last_process. A record is taken at a rising edge with start high
// and busy low. Records without last_process are stored one per cycle and give no
// result; busy stays low while loading. Records beyond MAX_PROCS are dropped and
// the run reports table_overflowed. A burst length of zero counts as one.
// The record marked last_process raises busy and starts the run. Each run step
// searches the n held records through the registered record memory port, then
// decides in the eval state and commits in the commit state; there are at most
// about 3n steps. Then one result word per process is produced in arrival
// order, each after a search of the held records. A result word is marked by
// strobe for exactly one cycle; the receiver cannot stall it. busy falls
// together with the word that carries last_result, and the next batch may be
// loaded from that cycle on. Reset clears the record count, overflow mark,
// finished flags and clock; the record memories themselves are not cleared,
// and only loaded entries are read.
module preemptive_priority_scheduler_unit #(
	parameter int unsigned MAX_PROCS = pps_pkg::DEF_MAX_PROCS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [pps_pkg::ARR_W-1:0]      arrival_time,
	input  logic [pps_pkg::BURST_W-1:0]    burst_length,
	input  logic [pps_pkg::PRIO_W-1:0]     prio_level,
	input  logic                           last_process,
	output logic                           strobe,
	output logic [pps_pkg::IDX_OUT_W-1:0]  proc_index,
	output logic [pps_pkg::OUT_TIME_W-1:0] completion_time,
	output logic [pps_pkg::OUT_TIME_W-1:0] turnaround_time,
	output logic [pps_pkg::OUT_TIME_W-1:0] waiting_time,
	output logic                           table_overflowed,
	output logic                           last_result
);
	import pps_pkg::*;

	// Commands flow from the controller, status flows back from the datapath.
	cmd_t cmd;
	sts_t sts;

	pps_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.last_process (last_process),
		.sts          (sts),
		.cmd          (cmd),
		.busy         (busy)
	);

	// The datapath holds the record memories and the simulated clock; the
	// clock starts at zero, which reaches the earliest arrival through one
	// idle step when no record arrives at tick zero.
	pps_dpath #(
		.MAX_PROCS (MAX_PROCS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.arrival_time     (arrival_time),
		.burst_length     (burst_length),
		.prio_level       (prio_level),
		.strobe           (strobe),
		.proc_index       (proc_index),
		.completion_time  (completion_time),
		.turnaround_time  (turnaround_time),
		.waiting_time     (waiting_time),
		.table_overflowed (table_overflowed),
		.last_result      (last_result)
	);

endmodule

FILE: src/pps_checker.sv
// Port-level assertions of the priority scheduler and their bind to the top level.
module pps_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           last_process,
	input logic                           strobe,
	input logic                           last_result,
	input logic [pps_pkg::OUT_TIME_W-1:0] completion_time,
	input logic [pps_pkg::OUT_TIME_W-1:0] turnaround_time,
	input logic [pps_pkg::OUT_TIME_W-1:0] waiting_time
);
	import pps_pkg::*;

	// A result word only follows a cycle in which a run was in progress.
	a_word_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result word without a run in progress");

	// The final word of a run releases the block.
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_result |-> !busy)
		else $error("block still busy with the final word");

	// A word that is not the final one keeps the run going.
	a_more_words: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_result |=> busy)
		else $error("run ended before its final word");

	// The final record of a batch starts a run.
	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_process |=> busy)
		else $error("final record did not start a run");

	// Completion covers turnaround, and turnaround covers waiting.
	a_time_order: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (completion_time >= turnaround_time) &&
		           (turnaround_time >= waiting_time))
		else $error("reported times out of order");

endmodule

bind preemptive_priority_scheduler_unit pps_checker u_pps_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.last_process    (last_process),
	.strobe          (strobe),
	.last_result     (last_result),
	.completion_time (completion_time),
	.turnaround_time (turnaround_time),
	.waiting_time    (waiting_time)
);
